// File: rtl/mbht_pkg.sv
// shared constants for the button hold tracker
package mbht_pkg;

  localparam int NUM_BUTTONS = 32;
  localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  localparam int ACT_W  = 2;
  localparam int BIDX_W = 5;
  localparam int KEY_W  = 11;
  localparam int TIME_W = 32;
  localparam int LEN_W  = 16;
  localparam int FRAC_W = 16;
  localparam int STAT_W = 3;
  localparam int Q_W    = 15;

  localparam logic [ACT_W-1:0] ACT_DOWN  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_UP    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_REPEAT    = 3'd1;
  localparam logic [STAT_W-1:0] ST_DROP      = 3'd2;
  localparam logic [STAT_W-1:0] ST_UNMATCHED = 3'd3;
  localparam logic [STAT_W-1:0] ST_OTHER     = 3'd4;

  localparam logic [KEY_W-1:0]  KEY_CONSOLE = '1;
  localparam logic [FRAC_W-1:0] ONE_Q15     = 16'h8000;

endpackage

// File: rtl/multi_source_button_hold_tracker_core.sv
// Button hold tracker: a table of buttons, each held by up to two keys, with
// hold-time accounting and a per-frame held fraction in Q1.15. Items are
// worked one at a time; in_ready is high only while the sequencer is idle,
// but a finished result waiting in the output register does not block the
// next transfer in. A key event passes through the execute and done steps,
// and a release of the last key also through an add step that adds hold time
// through the shared 32-bit adder. A frame query may add, then compares and
// runs the restoring divider, which produces one quotient bit per cycle;
// queries whose fraction is 0 or 1.0 skip the divider.
module multi_source_button_hold_tracker_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mbht_pkg::ACT_W-1:0]          action,
  input  logic [mbht_pkg::BIDX_W-1:0]         button_index,
  input  logic signed [mbht_pkg::KEY_W-1:0]   key_id,
  input  logic [mbht_pkg::TIME_W-1:0]         timestamp,
  input  logic [mbht_pkg::TIME_W-1:0]         frame_time,
  input  logic [mbht_pkg::LEN_W-1:0]          frame_length,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mbht_pkg::FRAC_W-1:0]         held_fraction,
  output logic                                pressed,
  output logic                                active,
  output logic [mbht_pkg::STAT_W-1:0]         status
);
  import mbht_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state;

  // button table
  logic [KEY_W-1:0]  first_holder  [NUM_BUTTONS];
  logic [KEY_W-1:0]  second_holder [NUM_BUTTONS];
  logic [TIME_W-1:0] press_time    [NUM_BUTTONS];
  logic [TIME_W-1:0] held_ms       [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] is_active;
  logic [NUM_BUTTONS-1:0] was_pressed;
  logic [LEN_W-1:0]  last_frame_length;

  // latched item
  logic [ACT_W-1:0]  act_r;
  logic [BIDX_W-1:0] bidx_r;
  logic [KEY_W-1:0]  key_r;
  logic [TIME_W-1:0] ts_r;
  logic [TIME_W-1:0] ft_r;
  logic [LEN_W-1:0]  len_r;

  // working registers
  logic [TIME_W-1:0] m;
  logic [TIME_W-1:0] diff;
  logic [FRAC_W-1:0] res_frac;
  logic              res_pr;
  logic              res_act;
  logic [STAT_W-1:0] res_st;

  logic [IDX_W-1:0]  idx;
  logic              in_range;
  logic [KEY_W-1:0]  fh;
  logic [KEY_W-1:0]  sh;
  logic [TIME_W-1:0] pt;
  logic [TIME_W-1:0] hm;
  logic              ia;
  logic              wp;
  logic [KEY_W-1:0]  other;
  logic [TIME_W-1:0] sum;
  logic              m_pos;
  logic              m_full;
  logic              div_start;
  logic              div_done;
  logic [Q_W-1:0]    div_q;

  assign idx      = IDX_W'(bidx_r);
  assign in_range = 32'(bidx_r) < NUM_BUTTONS;
  assign fh       = first_holder[idx];
  assign sh       = second_holder[idx];
  assign pt       = press_time[idx];
  assign hm       = held_ms[idx];
  assign ia       = is_active[idx];
  assign wp       = was_pressed[idx];
  assign other    = (key_r == fh) ? sh : fh;
  assign sum      = m + diff;

  // m read as signed: positive means nonzero with a clear sign bit
  assign m_pos     = !m[TIME_W-1] && (m != '0);
  assign m_full    = m >= TIME_W'(len_r);
  assign div_start = (state == S_CMP) && m_pos && !m_full;

  assign in_ready = (state == S_IDLE);

  mbht_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (m[LEN_W-1:0]),
    .divisor  (len_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      out_valid         <= 1'b0;
      is_active         <= '0;
      was_pressed       <= '0;
      last_frame_length <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        first_holder[i]  <= '0;
        second_holder[i] <= '0;
        press_time[i]    <= '0;
        held_ms[i]       <= '0;
      end
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            act_r  <= action;
            bidx_r <= button_index;
            key_r  <= key_id;
            ts_r   <= timestamp;
            ft_r   <= frame_time;
            len_r  <= frame_length;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_frac <= '0;
          res_st   <= ST_OK;
          res_pr   <= ia | wp;
          res_act  <= ia;
          state    <= S_DONE;
          if (!in_range) begin
            res_pr  <= 1'b0;
            res_act <= 1'b0;
          end else begin
            case (act_r)
              ACT_DOWN: begin
                if (key_r == fh || key_r == sh) begin
                  res_st <= ST_REPEAT;
                end else if (fh == '0 || sh == '0) begin
                  if (fh == '0) begin
                    first_holder[idx] <= key_r;
                  end else begin
                    second_holder[idx] <= key_r;
                  end
                  if (!ia) begin
                    press_time[idx]  <= ts_r;
                    is_active[idx]   <= 1'b1;
                    was_pressed[idx] <= 1'b1;
                  end
                  res_pr  <= 1'b1;
                  res_act <= 1'b1;
                end else begin
                  res_st <= ST_DROP;
                end
              end
              ACT_UP: begin
                if (key_r == KEY_CONSOLE) begin
                  first_holder[idx]  <= '0;
                  second_holder[idx] <= '0;
                  is_active[idx]     <= 1'b0;
                  res_pr             <= wp;
                  res_act            <= 1'b0;
                end else if (key_r == fh || key_r == sh) begin
                  if (key_r == fh) begin
                    first_holder[idx] <= '0;
                  end else begin
                    second_holder[idx] <= '0;
                  end
                  if (other != '0) begin
                    res_st <= ST_OTHER;
                  end else begin
                    // last key up: accumulate hold time
                    is_active[idx] <= 1'b0;
                    res_pr         <= wp;
                    res_act        <= 1'b0;
                    m              <= hm;
                    if (ts_r != '0) begin
                      diff <= ts_r - pt;
                    end else begin
                      diff <= TIME_W'(last_frame_length >> 1);
                    end
                    state <= S_ADD;
                  end
                end else begin
                  res_st <= ST_UNMATCHED;
                end
              end
              ACT_QUERY: begin
                last_frame_length <= len_r;
                was_pressed[idx]  <= 1'b0;
                held_ms[idx]      <= '0;
                m                 <= hm;
                state             <= S_CMP;
                if (ia) begin
                  press_time[idx] <= ft_r;
                  if (pt == '0) begin
                    m <= ft_r;
                  end else begin
                    diff  <= ft_r - pt;
                    state <= S_ADD;
                  end
                end
              end
              default: begin
                res_pr  <= 1'b0;
                res_act <= 1'b0;
              end
            endcase
          end
        end
        S_ADD: begin
          if (act_r == ACT_UP) begin
            held_ms[idx] <= sum;
            state        <= S_DONE;
          end else begin
            m     <= sum;
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (!m_pos) begin
            res_frac <= '0;
            state    <= S_DONE;
          end else if (m_full) begin
            res_frac <= ONE_Q15;
            state    <= S_DONE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_frac <= FRAC_W'(div_q);
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            held_fraction <= res_frac;
            pressed       <= res_pr;
            active        <= res_act;
            status        <= res_st;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> held_fraction <= ONE_Q15)
    else $error("held fraction above one");

  a_event_no_frac: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> held_fraction == '0)
    else $error("key event result carries a fraction");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while an item is in work");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide step");

endmodule

// File: rtl/mbht_div.sv
// restoring divider, one quotient bit per cycle, for dividend < divisor
module mbht_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [mbht_pkg::LEN_W-1:0]  dividend,
  input  logic [mbht_pkg::LEN_W-1:0]  divisor,
  output logic                        done,
  output logic [mbht_pkg::Q_W-1:0]    quotient
);
  import mbht_pkg::*;

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [LEN_W-1:0] rem;
  logic [LEN_W-1:0] den;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [LEN_W:0]   shifted;
  logic             fits;

  assign shifted = {rem, 1'b0};
  assign fits    = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= dividend;
        den      <= divisor;
        quotient <= '0;
        cnt      <= CNT_W'(Q_W);
        busy     <= 1'b1;
      end else if (busy) begin
        // remainder stays below the divisor, so it fits back in LEN_W bits
        if (fits) begin
          rem <= LEN_W'(shifted - {1'b0, den});
        end else begin
          rem <= shifted[LEN_W-1:0];
        end
        quotient <= {quotient[Q_W-2:0], fits};
        cnt      <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
